FILE: hw/rtl/clock_page_frame_allocator_defines.svh
// ----------------------------------------------------------------------------
// Clock page frame allocator assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CLOCK_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define CLOCK_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define CPFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CPFA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPFA_ASSERT(label, prop, msg)
`define CPFA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: hw/rtl/cpfa_pkg.sv
// ----------------------------------------------------------------------------
// Clock page frame allocator package
// Command codes and status codes shared by the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpfa_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_RELEASE   = 2'd1,
        CMD_REFERENCE = 2'd2
    } cmd_t;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage

FILE: hw/rtl/clock_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// Clock page frame allocator
// Hands out physical page frames from a free stack and, when the stack is
// empty, picks a victim with a clock sweep over the per-frame use bits.
//
// Channel   Handshake        Ports
// command   start / busy     command, virtual_page, owner_id, has_swap_copy,
//                            frame_index, is_write
// result    done (strobe)    frame, evicted, old_virtual_page, old_owner,
//                            write_back, new_swap_slot, status
//
// An item is taken when start is high and busy is low; its result shows on
// done for one cycle. An allocate from the free stack goes through S_POP, a
// release and a reference through S_CHECK; an unknown code or an out-of-range
// frame index is answered from S_IDLE. An allocate that evicts runs S_SWEEP,
// one frame of the sweep per cycle through the single read port of the frame
// table. After reset the block sweeps the frame table and the free stack once
// in S_CLEAR, with busy high. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "clock_page_frame_allocator_defines.svh"

module clock_page_frame_allocator
    import cpfa_pkg::*;
#(
    parameter int FRAMES     = 32,
    parameter int VPAGE_BITS = 12,
    parameter int OWNER_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    command,
    input  logic [VPAGE_BITS-1:0]         virtual_page,
    input  logic [OWNER_BITS-1:0]         owner_id,
    input  logic                          has_swap_copy,
    input  logic [$clog2(FRAMES)-1:0]     frame_index,
    input  logic                          is_write,
    output logic                          done,
    output logic [$clog2(FRAMES)-1:0]     frame,
    output logic                          evicted,
    output logic [VPAGE_BITS-1:0]         old_virtual_page,
    output logic [OWNER_BITS-1:0]         old_owner,
    output logic                          write_back,
    output logic                          new_swap_slot,
    output logic                          status
);

    localparam int FRAME_BITS = $clog2(FRAMES);
    localparam int COUNT_BITS = $clog2(FRAMES + 1);
    localparam logic [FRAME_BITS-1:0] LAST_FRAME  = FRAME_BITS'(FRAMES - 1);
    localparam logic [COUNT_BITS-1:0] FRAME_COUNT = COUNT_BITS'(FRAMES);

    typedef struct packed {
        logic                  in_use;
        logic                  used;
        logic                  modified;
        logic                  swap_backed;
        logic [VPAGE_BITS-1:0] page;
        logic [OWNER_BITS-1:0] owner;
    } entry_t;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_POP   = 5'b00100,
        S_SWEEP = 5'b01000,
        S_CHECK = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [FRAME_BITS-1:0]  hand_reg, hand_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [COUNT_BITS-1:0]  steps_reg, steps_next;
    logic                   done_reg;

    cmd_t                   cmd_reg;
    logic [VPAGE_BITS-1:0]  vpage_reg;
    logic [OWNER_BITS-1:0]  owner_reg;
    logic                   swap_reg;
    logic [FRAME_BITS-1:0]  idx_reg;
    logic                   wr_reg;

    logic [FRAME_BITS-1:0]  frame_reg;
    logic                   evicted_reg;
    logic [VPAGE_BITS-1:0]  page_reg;
    logic [OWNER_BITS-1:0]  owner_out_reg;
    logic                   wb_reg;
    logic                   nss_reg;
    logic                   status_reg;

    logic                   res_load;
    logic [FRAME_BITS-1:0]  res_frame;
    logic                   res_evicted;
    logic [VPAGE_BITS-1:0]  res_page;
    logic [OWNER_BITS-1:0]  res_owner;
    logic                   res_wb;
    logic                   res_nss;
    logic                   res_status;

    entry_t                 frame_mem [FRAMES];
    entry_t                 tab_q;
    entry_t                 tab_wdata;
    entry_t                 new_entry;
    logic                   tab_we;
    logic                   tab_re;
    logic [FRAME_BITS-1:0]  tab_waddr;
    logic [FRAME_BITS-1:0]  tab_raddr;

    logic [FRAME_BITS-1:0]  stack_mem [FRAMES];
    logic [FRAME_BITS-1:0]  stk_q;
    logic [FRAME_BITS-1:0]  stk_wdata;
    logic                   stk_we;
    logic                   stk_re;
    logic [FRAME_BITS-1:0]  stk_waddr;
    logic [COUNT_BITS-1:0]  count_dec;

    logic [FRAME_BITS-1:0]  hand_step;
    logic                   accept;
    logic                   idx_in_range;

    assign busy         = (state_reg != S_IDLE);
    assign accept       = start && !busy;
    assign hand_step    = (hand_reg == LAST_FRAME) ? '0 : hand_reg + FRAME_BITS'(1);
    assign count_dec    = count_reg - COUNT_BITS'(1);
    assign idx_in_range = (COUNT_BITS'(frame_index) < FRAME_COUNT);

    assign new_entry = '{
        in_use:      1'b1,
        used:        1'b0,
        modified:    1'b0,
        swap_backed: swap_reg,
        page:        vpage_reg,
        owner:       owner_reg
    };

    always_comb
    begin
        state_next  = state_reg;
        hand_next   = hand_reg;
        count_next  = count_reg;
        steps_next  = steps_reg;
        tab_we      = 1'b0;
        tab_waddr   = hand_reg;
        tab_wdata   = tab_q;
        tab_re      = 1'b0;
        tab_raddr   = hand_reg;
        stk_we      = 1'b0;
        stk_waddr   = count_reg[FRAME_BITS-1:0];
        stk_wdata   = idx_reg;
        stk_re      = 1'b0;
        res_load    = 1'b0;
        res_frame   = '0;
        res_evicted = 1'b0;
        res_page    = '0;
        res_owner   = '0;
        res_wb      = 1'b0;
        res_nss     = 1'b0;
        res_status  = STATUS_OK;

        unique case (state_reg)
            S_CLEAR:
            begin
                tab_we    = 1'b1;
                tab_waddr = hand_reg;
                tab_wdata = '0;
                stk_we    = 1'b1;
                stk_waddr = hand_reg;
                stk_wdata = LAST_FRAME - hand_reg;
                hand_next = hand_step;
                if (hand_reg == LAST_FRAME)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd_t'(command)) inside
                        CMD_ALLOC:
                        begin
                            if (count_reg != '0)
                            begin
                                stk_re     = 1'b1;
                                state_next = S_POP;
                            end
                            else
                            begin
                                tab_re     = 1'b1;
                                tab_raddr  = hand_reg;
                                steps_next = '0;
                                state_next = S_SWEEP;
                            end
                        end
                        CMD_RELEASE, CMD_REFERENCE:
                        begin
                            if (idx_in_range)
                            begin
                                tab_re     = 1'b1;
                                tab_raddr  = frame_index;
                                state_next = S_CHECK;
                            end
                            else
                            begin
                                res_load   = 1'b1;
                                res_status = STATUS_ERR;
                            end
                        end
                        default:
                        begin
                            res_load   = 1'b1;
                            res_status = STATUS_ERR;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                tab_we     = 1'b1;
                tab_waddr  = stk_q;
                tab_wdata  = new_entry;
                count_next = count_dec;
                res_load   = 1'b1;
                res_frame  = stk_q;
                state_next = S_IDLE;
            end
            S_SWEEP:
            begin
                tab_we    = 1'b1;
                tab_waddr = hand_reg;
                hand_next = hand_step;
                if (tab_q.used && steps_reg != FRAME_COUNT)
                begin
                    tab_wdata      = tab_q;
                    tab_wdata.used = 1'b0;
                    tab_re         = 1'b1;
                    tab_raddr      = hand_step;
                    steps_next     = steps_reg + COUNT_BITS'(1);
                end
                else
                begin
                    tab_wdata  = new_entry;
                    res_load   = 1'b1;
                    res_frame  = hand_reg;
                    if (tab_q.in_use)
                    begin
                        res_evicted = 1'b1;
                        res_page    = tab_q.page;
                        res_owner   = tab_q.owner;
                        res_wb      = tab_q.modified;
                        res_nss     = tab_q.modified && !tab_q.swap_backed;
                    end
                    state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                res_load   = 1'b1;
                state_next = S_IDLE;
                if (!tab_q.in_use)
                begin
                    res_status = STATUS_ERR;
                end
                else
                begin
                    tab_we    = 1'b1;
                    tab_waddr = idx_reg;
                    unique case (cmd_reg)
                        CMD_RELEASE:
                        begin
                            tab_wdata.in_use   = 1'b0;
                            tab_wdata.used     = 1'b0;
                            tab_wdata.modified = 1'b0;
                            if (count_reg < FRAME_COUNT)
                            begin
                                stk_we     = 1'b1;
                                count_next = count_reg + COUNT_BITS'(1);
                            end
                        end
                        default:
                        begin
                            tab_wdata.used     = 1'b1;
                            tab_wdata.modified = tab_q.modified || wr_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            hand_reg  <= '0;
            count_reg <= FRAME_COUNT;
            steps_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hand_reg  <= hand_next;
            count_reg <= count_next;
            steps_reg <= steps_next;
            done_reg  <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_t'(command);
            vpage_reg <= virtual_page;
            owner_reg <= owner_id;
            swap_reg  <= has_swap_copy;
            idx_reg   <= frame_index;
            wr_reg    <= is_write;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            frame_reg     <= res_frame;
            evicted_reg   <= res_evicted;
            page_reg      <= res_page;
            owner_out_reg <= res_owner;
            wb_reg        <= res_wb;
            nss_reg       <= res_nss;
            status_reg    <= res_status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            frame_mem[tab_waddr] <= tab_wdata;
        end
        if (tab_re)
        begin
            tab_q <= frame_mem[tab_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_q <= stack_mem[count_dec[FRAME_BITS-1:0]];
        end
    end

    assign done             = done_reg;
    assign frame            = frame_reg;
    assign evicted          = evicted_reg;
    assign old_virtual_page = page_reg;
    assign old_owner        = owner_out_reg;
    assign write_back       = wb_reg;
    assign new_swap_slot    = nss_reg;
    assign status           = status_reg;

    `CPFA_ASSERT(a_done_not_busy, done |-> !busy, "result strobe while the block is busy")
    `CPFA_ASSERT(a_count_bound, count_reg <= FRAME_COUNT, "free count above frame total")
    `CPFA_ASSERT(a_evict_empty, done && evicted |-> count_reg == '0, "eviction with free frames left")
    `CPFA_ASSERT(a_error_clean, done && status |-> !evicted && frame == '0, "error result with a frame")
    `CPFA_ASSERT(a_hand_idle, state_reg == S_IDLE |=> $stable(hand_reg), "clock hand moved while idle")

endmodule

FILE: test/tb_clock_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// Clock page frame allocator testbench
// Drives allocate, release and reference items through the start / busy
// handshake and checks every result against a cycle-free model of the frame
// table, the free stack and the clock sweep kept in the testbench. A short
// directed run covers the error cases and the field extremes. Random items
// then keep the free stack mostly empty so that sweeps and evictions happen
// often, with the sender idling at different rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_clock_page_frame_allocator;
    import cpfa_pkg::*;

    localparam int NFRAMES    = 32;
    localparam int VPAGE_BITS = 12;
    localparam int OWNER_BITS = 8;
    localparam int FIDX_BITS  = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]            command;
        logic [VPAGE_BITS-1:0] virtual_page;
        logic [OWNER_BITS-1:0] owner_id;
        logic                  has_swap_copy;
        logic [FIDX_BITS-1:0]  frame_index;
        logic                  is_write;
    } request_t;

    typedef struct packed {
        logic [FIDX_BITS-1:0]  frame;
        logic                  evicted;
        logic [VPAGE_BITS-1:0] old_virtual_page;
        logic [OWNER_BITS-1:0] old_owner;
        logic                  write_back;
        logic                  new_swap_slot;
        logic                  status;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            command = CMD_ALLOC;
    logic [VPAGE_BITS-1:0] virtual_page = '0;
    logic [OWNER_BITS-1:0] owner_id = '0;
    logic                  has_swap_copy = 1'b0;
    logic [FIDX_BITS-1:0]  frame_index = '0;
    logic                  is_write = 1'b0;
    logic                  done;
    logic [FIDX_BITS-1:0]  frame;
    logic                  evicted;
    logic [VPAGE_BITS-1:0] old_virtual_page;
    logic [OWNER_BITS-1:0] old_owner;
    logic                  write_back;
    logic                  new_swap_slot;
    logic                  status;

    request_t pending_requests[$];
    outcome_t expected_outcomes[$];
    request_t next_request;
    logic     taken = 1'b0;
    int       sender_idle_pct = 37;
    int       mismatches = 0;
    int       cycle_count = 0;

    logic                  page_in_use[NFRAMES];
    logic                  page_used[NFRAMES];
    logic                  page_dirty[NFRAMES];
    logic                  page_swapped[NFRAMES];
    logic [VPAGE_BITS-1:0] page_vpage[NFRAMES];
    logic [OWNER_BITS-1:0] page_owner[NFRAMES];
    logic [FIDX_BITS-1:0]  free_frames[NFRAMES];
    int                    free_depth;
    logic [FIDX_BITS-1:0]  clock_hand;

    clock_page_frame_allocator #(
        .FRAMES     (NFRAMES),
        .VPAGE_BITS (VPAGE_BITS),
        .OWNER_BITS (OWNER_BITS)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .command          (command),
        .virtual_page     (virtual_page),
        .owner_id         (owner_id),
        .has_swap_copy    (has_swap_copy),
        .frame_index      (frame_index),
        .is_write         (is_write),
        .done             (done),
        .frame            (frame),
        .evicted          (evicted),
        .old_virtual_page (old_virtual_page),
        .old_owner        (old_owner),
        .write_back       (write_back),
        .new_swap_slot    (new_swap_slot),
        .status           (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic outcome_t predict_outcome(input request_t req);
        outcome_t             res;
        logic [FIDX_BITS-1:0] f;
        int                   steps;
        res = '0;
        if (req.command == CMD_ALLOC)
        begin
            if (free_depth > 0)
            begin
                free_depth--;
                f = free_frames[free_depth];
            end
            else
            begin
                steps = 0;
                while (steps < NFRAMES && page_used[clock_hand])
                begin
                    page_used[clock_hand] = 1'b0;
                    clock_hand++;
                    steps++;
                end
                f = clock_hand;
                clock_hand++;
                if (page_in_use[f])
                begin
                    res.evicted          = 1'b1;
                    res.old_virtual_page = page_vpage[f];
                    res.old_owner        = page_owner[f];
                    res.write_back       = page_dirty[f];
                    res.new_swap_slot    = page_dirty[f] && !page_swapped[f];
                end
            end
            page_in_use[f]  = 1'b1;
            page_used[f]    = 1'b0;
            page_dirty[f]   = 1'b0;
            page_swapped[f] = req.has_swap_copy;
            page_vpage[f]   = req.virtual_page;
            page_owner[f]   = req.owner_id;
            res.frame = f;
        end
        else if (req.command == CMD_UNKNOWN || !page_in_use[req.frame_index])
        begin
            res.status = STATUS_ERR;
        end
        else if (req.command == CMD_RELEASE)
        begin
            page_in_use[req.frame_index] = 1'b0;
            page_used[req.frame_index]   = 1'b0;
            page_dirty[req.frame_index]  = 1'b0;
            if (free_depth < NFRAMES)
            begin
                free_frames[free_depth] = req.frame_index;
                free_depth++;
            end
        end
        else
        begin
            page_used[req.frame_index] = 1'b1;
            if (req.is_write)
                page_dirty[req.frame_index] = 1'b1;
        end
        return res;
    endfunction

    function automatic request_t make_request(input logic [1:0] cmd,
                                              input int vpage, input int owner,
                                              input int swap, input int idx,
                                              input int wr);
        request_t req;
        req.command       = cmd;
        req.virtual_page  = VPAGE_BITS'(vpage);
        req.owner_id      = OWNER_BITS'(owner);
        req.has_swap_copy = swap[0];
        req.frame_index   = FIDX_BITS'(idx);
        req.is_write      = wr[0];
        return req;
    endfunction

    function automatic request_t random_request();
        request_t req;
        int       r;
        r = $urandom_range(99);
        req = make_request(CMD_REFERENCE, $urandom_range(4095), $urandom_range(255),
                           $urandom_range(1), $urandom_range(NFRAMES - 1),
                           $urandom_range(1));
        if (r < 46)
            req.command = CMD_ALLOC;
        else if (r < 56)
            req.command = CMD_RELEASE;
        else if (r < 97)
            req.command = CMD_REFERENCE;
        else
            req.command = CMD_UNKNOWN;
        return req;
    endfunction

    // Now and then every frame is referenced before an allocate, so that the
    // sweep has to go all the way round the frame table.
    task automatic queue_random_items(input int count);
        int added;
        int f;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(59) == 0)
            begin
                for (f = 0; f < NFRAMES; f++)
                    pending_requests.push_back(make_request(CMD_REFERENCE,
                        $urandom_range(4095), $urandom_range(255), $urandom_range(1),
                        f, $urandom_range(1)));
                pending_requests.push_back(make_request(CMD_ALLOC, $urandom_range(4095),
                    $urandom_range(255), $urandom_range(1), $urandom_range(NFRAMES - 1),
                    $urandom_range(1)));
                added += NFRAMES + 1;
            end
            else
            begin
                pending_requests.push_back(random_request());
                added++;
            end
        end
    endtask

    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || start || expected_outcomes.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!start || taken))
        begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                next_request  = pending_requests.pop_front();
                start         <= 1'b1;
                command       <= next_request.command;
                virtual_page  <= next_request.virtual_page;
                owner_id      <= next_request.owner_id;
                has_swap_copy <= next_request.has_swap_copy;
                frame_index   <= next_request.frame_index;
                is_write      <= next_request.is_write;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor_proc
        outcome_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_clock_page_frame_allocator: FAIL");
            $finish;
        end
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("result strobe with no item outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    check_field("frame", 32'(want.frame), 32'(frame));
                    check_field("evicted", 32'(want.evicted), 32'(evicted));
                    check_field("old_virtual_page", 32'(want.old_virtual_page),
                                32'(old_virtual_page));
                    check_field("old_owner", 32'(want.old_owner), 32'(old_owner));
                    check_field("write_back", 32'(want.write_back), 32'(write_back));
                    check_field("new_swap_slot", 32'(want.new_swap_slot),
                                32'(new_swap_slot));
                    check_field("status", 32'(want.status), 32'(status));
                end
            end
            if (start && !busy)
                expected_outcomes.push_back(predict_outcome(request_t'({command,
                    virtual_page, owner_id, has_swap_copy, frame_index, is_write})));
            taken <= start && !busy;
        end
    end

    initial
    begin
        for (int i = 0; i < NFRAMES; i++)
        begin
            page_in_use[i]  = 1'b0;
            page_used[i]    = 1'b0;
            page_dirty[i]   = 1'b0;
            page_swapped[i] = 1'b0;
            page_vpage[i]   = '0;
            page_owner[i]   = '0;
            free_frames[i]  = FIDX_BITS'(NFRAMES - 1 - i);
        end
        free_depth = NFRAMES;
        clock_hand = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        #1;

        // Error cases on an empty table come first, then allocations at the
        // field extremes and release and reference of live and freed frames.
        sender_idle_pct = 37;
        pending_requests.push_back(make_request(CMD_RELEASE, 0, 0, 0, 5, 0));
        pending_requests.push_back(make_request(CMD_REFERENCE, 4095, 255, 1, 31, 1));
        pending_requests.push_back(make_request(CMD_UNKNOWN, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(CMD_ALLOC, 4095, 255, 1, 31, 1));
        pending_requests.push_back(make_request(CMD_ALLOC, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(CMD_REFERENCE, 0, 0, 0, 0, 1));
        pending_requests.push_back(make_request(CMD_REFERENCE, 0, 0, 0, 1, 0));
        pending_requests.push_back(make_request(CMD_RELEASE, 0, 0, 0, 1, 0));
        pending_requests.push_back(make_request(CMD_RELEASE, 0, 0, 0, 1, 0));
        pending_requests.push_back(make_request(CMD_REFERENCE, 0, 0, 0, 1, 1));
        pending_requests.push_back(make_request(CMD_ALLOC, 'hAAA, 'h55, 0, 0, 0));
        pending_requests.push_back(make_request(CMD_UNKNOWN, 4095, 255, 1, 31, 1));
        pending_requests.push_back(make_request(CMD_REFERENCE, 0, 0, 0, 31, 1));
        pending_requests.push_back(make_request(CMD_RELEASE, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(CMD_ALLOC, 'h555, 'hAA, 1, 16, 0));
        pending_requests.push_back(make_request(CMD_REFERENCE, 0, 0, 0, 0, 1));
        pending_requests.push_back(make_request(CMD_RELEASE, 4095, 255, 1, 0, 1));
        queue_random_items(320);
        wait_until_drained();

        sender_idle_pct = 62;
        queue_random_items(320);
        wait_until_drained();

        sender_idle_pct = 0;
        queue_random_items(310);
        wait_until_drained();

        repeat (2 * NFRAMES) @(posedge clk);
        #1;
        if (mismatches == 0)
            $display("tb_clock_page_frame_allocator: PASS");
        else
            $display("tb_clock_page_frame_allocator: FAIL");
        $finish;
    end

endmodule

FILE: clock_page_frame_allocator.f
+incdir+hw/rtl
hw/rtl/cpfa_pkg.sv
hw/rtl/clock_page_frame_allocator.sv
test/tb_clock_page_frame_allocator.sv
